[design/stepped_fade_soft_volume_assert.svh]
// Assertion macros for the stepped fade soft volume block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef STEPPED_FADE_SOFT_VOLUME_ASSERT_SVH
`define STEPPED_FADE_SOFT_VOLUME_ASSERT_SVH

// check cons in the same cycle as ante
`define SFSV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfsv assertion failed");

// check cons in the cycle after ante
`define SFSV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfsv assertion failed");

`endif

[design/sfsv_pkg.sv]
// Package for the stepped fade soft volume block: types, codes, constants
// and the fade step functions. No dependencies.
package sfsv_pkg;

  localparam int VOL_W    = 7;
  localparam int SMP_W    = 16;
  localparam int PROD_W   = 23;
  localparam int MAG_W    = 22;
  localparam int QUO_W    = 20;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 25;
  localparam int CFG_DW   = 7;
  localparam int CFG_IW   = 3;

  typedef logic [VOL_W-1:0]  vol_t;
  typedef logic [1:0]        op_t;
  typedef logic [CFG_IW-1:0] cfg_idx_t;

  localparam vol_t VOL_FULL = 7'd100;

  // truncated divide by 25 of a 20-bit value: (m * RECIP) >> RECIP_SH
  localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;

  localparam op_t OP_SAMPLE  = 2'd0;
  localparam op_t OP_BLOCK   = 2'd1;
  localparam op_t OP_RESTART = 2'd2;

  localparam cfg_idx_t REG_LEFT_MAX  = 3'd0;
  localparam cfg_idx_t REG_RIGHT_MAX = 3'd1;
  localparam cfg_idx_t REG_FADE_IN   = 3'd2;
  localparam cfg_idx_t REG_FADE_OUT  = 3'd3;
  localparam cfg_idx_t REG_SIXTEEN   = 3'd4;
  localparam cfg_idx_t REG_STEREO    = 3'd5;

  function automatic vol_t step_down(input vol_t v);
    vol_t r;
    if (v > 7'd50) r = v - 7'd10;
    else if (v > 7'd10) r = v - 7'd5;
    else if (v > 7'd2) r = v - 7'd2;
    else if (v > 7'd0) r = v - 7'd1;
    else r = 7'd0;
    return r;
  endfunction

  function automatic vol_t step_up(input vol_t v, input vol_t cap);
    vol_t r;
    if (v < 7'd10) r = v + 7'd1;
    else if (v < 7'd50) r = v + 7'd5;
    else if (v < VOL_FULL) r = v + 7'd10;
    else r = v;
    return (r > cap) ? cap : r;
  endfunction

endpackage

[design/stepped_fade_soft_volume.sv]
// An accepted beat is registered in stage 1, then in the output stage;
// one beat per cycle unless out_ready stalls. Stage 1 does the volume
// multiply, stage 2 the reciprocal divide by 100 and the saturation.
// Reset: synchronous, active low; volumes 100, parity left, registers
// to their defaults, pipeline emptied.
// Depends on sfsv_pkg and stepped_fade_soft_volume_assert.svh.
`include "stepped_fade_soft_volume_assert.svh"

module stepped_fade_soft_volume (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  sfsv_pkg::cfg_idx_t            cfg_index,
  input  logic [sfsv_pkg::CFG_DW-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfsv_pkg::op_t                 in_operation,
  input  logic signed [sfsv_pkg::SMP_W-1:0] in_sample_in,
  input  logic                          in_near_end,
  input  logic                          in_decoder_idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [sfsv_pkg::SMP_W-1:0] out_sample_out,
  output sfsv_pkg::vol_t                out_left_volume_now,
  output sfsv_pkg::vol_t                out_right_volume_now
);
  import sfsv_pkg::*;

  vol_t left_max_r, right_max_r;
  logic fade_in_r, fade_out_r, sixteen_r, stereo_r;
  vol_t left_vol_r, right_vol_r, left_vol_nxt, right_vol_nxt;
  logic parity_r, parity_nxt;
  vol_t cfg_vol;

  logic                      s1_valid_r, s1_smp_r, s1_mode16_r;
  logic signed [PROD_W-1:0]  s1_prod_r;
  vol_t                      s1_lvol_r, s1_rvol_r;

  logic                      out_valid_r;
  logic signed [SMP_W-1:0]   out_sample_r;
  vol_t                      out_lvol_r, out_rvol_r;

  logic in_acc, s1_adv, out_free;
  logic is_smp;
  vol_t smp_vol;
  logic signed [SMP_W-1:0]   oper;
  logic signed [SMP_W+VOL_W:0] prod_full;

  logic                      neg;
  logic [MAG_W-1:0]          mag;
  logic [QUO_W+RECIP_W-1:0]  quo_full;
  logic [SMP_W-1:0]          quo;
  logic signed [SMP_W+1:0]   tval, t8;
  logic signed [SMP_W-1:0]   res;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_acc   = in_valid && in_ready;

  assign cfg_vol = (cfg_data > VOL_FULL) ? VOL_FULL : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_max_r  <= VOL_FULL;
      right_max_r <= VOL_FULL;
      fade_in_r   <= 1'b0;
      fade_out_r  <= 1'b0;
      sixteen_r   <= 1'b1;
      stereo_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_MAX:  left_max_r  <= cfg_vol;
        REG_RIGHT_MAX: right_max_r <= cfg_vol;
        REG_FADE_IN:   fade_in_r   <= cfg_data[0];
        REG_FADE_OUT:  fade_out_r  <= cfg_data[0];
        REG_SIXTEEN:   sixteen_r   <= cfg_data[0];
        REG_STEREO:    stereo_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    left_vol_nxt  = left_vol_r;
    right_vol_nxt = right_vol_r;
    parity_nxt    = parity_r;
    is_smp        = 1'b0;
    unique case (in_operation)
      OP_SAMPLE: begin
        is_smp     = 1'b1;
        parity_nxt = !parity_r;
      end
      OP_BLOCK: begin
        parity_nxt = 1'b0;
        if (fade_out_r && in_near_end) begin
          left_vol_nxt  = step_down(left_vol_r);
          right_vol_nxt = step_down(right_vol_r);
        end else if (fade_in_r && in_decoder_idle) begin
          left_vol_nxt  = step_up(left_vol_r, left_max_r);
          right_vol_nxt = step_up(right_vol_r, right_max_r);
        end
      end
      OP_RESTART: begin
        left_vol_nxt  = fade_in_r ? '0 : left_max_r;
        right_vol_nxt = fade_in_r ? '0 : right_max_r;
      end
      default: ;
    endcase
  end

  assign smp_vol   = (stereo_r && parity_r) ? right_vol_r : left_vol_r;
  assign oper      = sixteen_r ? in_sample_in
                               : $signed({8'd0, in_sample_in[7:0]}) - 16'sd128;
  assign prod_full = oper * $signed({1'b0, smp_vol});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_vol_r  <= VOL_FULL;
      right_vol_r <= VOL_FULL;
      parity_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        left_vol_r  <= left_vol_nxt;
        right_vol_r <= right_vol_nxt;
        parity_r    <= parity_nxt;
        s1_valid_r  <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_prod_r   <= prod_full[PROD_W-1:0];
      s1_smp_r    <= is_smp;
      s1_mode16_r <= sixteen_r;
      s1_lvol_r   <= left_vol_nxt;
      s1_rvol_r   <= right_vol_nxt;
    end
  end

  assign neg      = s1_prod_r[PROD_W-1];
  assign mag      = neg ? MAG_W'(-s1_prod_r) : MAG_W'(s1_prod_r);
  assign quo_full = mag[MAG_W-1:2] * RECIP_25;
  assign quo      = quo_full[RECIP_SH+SMP_W-1:RECIP_SH];
  assign tval     = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign t8       = tval + 18'sd128;

  always_comb begin
    if (!s1_smp_r) begin
      res = '0;
    end else if (s1_mode16_r) begin
      if (tval > 18'sd32767) res = 16'sh7fff;
      else if (tval < -18'sd32768) res = 16'sh8000;
      else res = tval[SMP_W-1:0];
    end else begin
      if (t8 > 18'sd255) res = 16'sd255;
      else if (t8 < 18'sd0) res = '0;
      else res = t8[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= res;
      out_lvol_r   <= s1_lvol_r;
      out_rvol_r   <= s1_rvol_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sample_out       = out_sample_r;
  assign out_left_volume_now  = out_lvol_r;
  assign out_right_volume_now = out_rvol_r;

  `SFSV_ASSERT_SAME(a_vol_range, 1'b1, (left_vol_r <= VOL_FULL) && (right_vol_r <= VOL_FULL))
  `SFSV_ASSERT_NEXT(a_acc_loads_s1, in_acc, s1_valid_r)
  `SFSV_ASSERT_NEXT(a_s1_stall_holds, s1_valid_r && !out_free, s1_valid_r && $stable(s1_prod_r))

endmodule
